[sv/xsrb_pkg.sv]
// ----------------------------------------------------------------------------
// xsrb_pkg
// Shared types and constants of the sprite row XOR blitter.
// ----------------------------------------------------------------------------
package xsrb_pkg;

	localparam int FRAME_WIDTH_DEF  = 64;
	localparam int FRAME_HEIGHT_DEF = 32;

	// width of the row_pixels port
	localparam int ROW_PIXELS_W = 64;
	// (y mod height) + row index stays below 63 + 15 + 1 for every legal height
	localparam int RSUM_W = 7;

	localparam logic [1:0] MODE_DRAW  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

endpackage

[sv/xsrb_frame_mem.sv]
// ----------------------------------------------------------------------------
// xsrb_frame_mem
// Frame store: one word per row, one write and one registered read per cycle,
// with per-row valid bits so a clear resets every row at once.
// ----------------------------------------------------------------------------
module xsrb_frame_mem #(
	parameter int FRAME_WIDTH  = xsrb_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = xsrb_pkg::FRAME_HEIGHT_DEF,
	localparam int ROW_W       = $clog2(FRAME_HEIGHT)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  xsrb_pkg::mem_ctl_t     ctl,
	input  logic [ROW_W-1:0]       rd_addr,
	input  logic [ROW_W-1:0]       wr_addr,
	input  logic [FRAME_WIDTH-1:0] wr_data,
	output logic [FRAME_WIDTH-1:0] rd_data
);

	logic [FRAME_WIDTH-1:0]  mem [FRAME_HEIGHT];
	logic [FRAME_HEIGHT-1:0] vld_q;
	logic [FRAME_WIDTH-1:0]  rd_word_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

[sv/xsrb_mask_gen.sv]
// ----------------------------------------------------------------------------
// xsrb_mask_gen
// Place one sprite byte into a frame row mask, bit 7 leftmost, dropping
// columns past the right edge.
// ----------------------------------------------------------------------------
module xsrb_mask_gen #(
	parameter int FRAME_WIDTH = xsrb_pkg::FRAME_WIDTH_DEF,
	localparam int COL_W      = $clog2(FRAME_WIDTH)
) (
	input  logic [7:0]             sprite,
	input  logic [COL_W-1:0]       col0,
	output logic [FRAME_WIDTH-1:0] mask
);

	always_comb begin
		logic [COL_W:0] col;
		mask = '0;
		for (int j = 0; j < 8; j++) begin
			col = (COL_W + 1)'(col0) + (COL_W + 1)'(j);
			if (col < (COL_W + 1)'(FRAME_WIDTH) && sprite[7 - j]) begin
				mask[col[COL_W-1:0]] = 1'b1;
			end
		end
	end

endmodule

[sv/xor_sprite_row_blitter_core.sv]
// ----------------------------------------------------------------------------
// xor_sprite_row_blitter_core
// XOR sprite row blitter over a one-bit frame store, with clear and row read.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word. The accept edge starts the frame store read;
// the commit edge, once the output can take the word, writes the row back
// and loads the result register. A row written back at the edge that reads
// it is forwarded, so back-to-back draws on the same row run at full rate.
// Clear resets the per-row valid bits. The collision flag restarts at row
// index zero and is final on the word marked last.
// ----------------------------------------------------------------------------
module xor_sprite_row_blitter_core #(
	parameter int FRAME_WIDTH  = xsrb_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = xsrb_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [7:0]                        sprite_bits,
	input  logic [7:0]                        x_pos,
	input  logic [7:0]                        y_pos,
	input  logic [3:0]                        row_index,
	input  logic                              last_row,
	input  logic [4:0]                        read_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              collision,
	output logic                              sprite_done,
	output logic [xsrb_pkg::ROW_PIXELS_W-1:0] row_pixels
);

	localparam int ROW_W  = $clog2(FRAME_HEIGHT);
	localparam int COL_W  = $clog2(FRAME_WIDTH);
	localparam int RSUM_W = xsrb_pkg::RSUM_W;

	logic [ROW_W-1:0] ymod_lut [256];
	logic [COL_W-1:0] xmod_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_lut
		assign ymod_lut[g] = ROW_W'(g % FRAME_HEIGHT);
		assign xmod_lut[g] = COL_W'(g % FRAME_WIDTH);
	end

	logic                   in_accept;
	logic                   s1_adv;
	logic                   s1_commit;
	logic [RSUM_W-1:0]      row_sum;
	logic [RSUM_W-1:0]      rr_ext;
	logic [ROW_W-1:0]       rd_addr_in;
	logic                   in_range_in;
	logic                   fwd_next;

	logic                   s1_valid_q;
	logic [1:0]             mode_s1;
	logic [7:0]             sprite_s1;
	logic [COL_W-1:0]       col0_s1;
	logic                   row_zero_s1;
	logic                   last_s1;
	logic [ROW_W-1:0]       addr_s1;
	logic                   in_range_s1;
	logic                   fwd_s1;
	logic [FRAME_WIDTH-1:0] fwd_word_s1;

	logic                   hit_flag_q;
	logic                   out_valid_q;
	logic                   collision_q;
	logic                   sprite_done_q;
	logic [xsrb_pkg::ROW_PIXELS_W-1:0] row_pixels_q;

	xsrb_pkg::mem_ctl_t     mem_ctl;
	logic [FRAME_WIDTH-1:0] rd_data;
	logic [FRAME_WIDTH-1:0] cur_word;
	logic [FRAME_WIDTH-1:0] mask;
	logic [FRAME_WIDTH-1:0] new_word;
	logic                   hit_row;
	logic                   coll;

	// input side: target row and read address
	assign row_sum    = RSUM_W'(ymod_lut[y_pos]) + RSUM_W'(row_index);
	assign rr_ext     = RSUM_W'(read_row);
	assign rd_addr_in = (mode == xsrb_pkg::MODE_READ) ? rr_ext[ROW_W-1:0]
		: row_sum[ROW_W-1:0];
	assign in_range_in = (mode == xsrb_pkg::MODE_READ)
		? (rr_ext < RSUM_W'(FRAME_HEIGHT)) : (row_sum < RSUM_W'(FRAME_HEIGHT));

	assign s1_adv    = !out_valid_q || out_ready;
	assign s1_commit = s1_valid_q && s1_adv;
	assign in_ready  = !s1_valid_q || s1_adv;
	assign in_accept = in_valid && in_ready;

	// forward the row written back at the edge that starts this read
	assign fwd_next = s1_commit && ((mode_s1 == xsrb_pkg::MODE_CLEAR)
		|| (mode_s1 == xsrb_pkg::MODE_DRAW && in_range_s1 && addr_s1 == rd_addr_in));

	// stage 1: merge sprite row into the frame row
	xsrb_mask_gen #(
		.FRAME_WIDTH(FRAME_WIDTH)
	) u_mask (
		.sprite(sprite_s1),
		.col0  (col0_s1),
		.mask  (mask)
	);

	assign cur_word = fwd_s1 ? fwd_word_s1 : rd_data;
	assign new_word = cur_word ^ mask;
	assign hit_row  = in_range_s1 && ((cur_word & mask) != '0);
	assign coll     = (row_zero_s1 ? 1'b0 : hit_flag_q) || hit_row;

	assign mem_ctl.rd  = in_accept;
	assign mem_ctl.wr  = s1_commit && mode_s1 == xsrb_pkg::MODE_DRAW && in_range_s1;
	assign mem_ctl.clr = s1_commit && mode_s1 == xsrb_pkg::MODE_CLEAR;

	xsrb_frame_mem #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.rd_addr(rd_addr_in),
		.wr_addr(addr_s1),
		.wr_data(new_word),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1     <= mode;
			sprite_s1   <= sprite_bits;
			col0_s1     <= xmod_lut[x_pos];
			row_zero_s1 <= (row_index == 4'd0);
			last_s1     <= last_row;
			addr_s1     <= rd_addr_in;
			in_range_s1 <= in_range_in;
			fwd_s1      <= fwd_next;
			fwd_word_s1 <= (mode_s1 == xsrb_pkg::MODE_CLEAR) ? '0 : new_word;
		end
		if (s1_commit) begin
			case (mode_s1)
				xsrb_pkg::MODE_DRAW: begin
					collision_q   <= coll;
					sprite_done_q <= last_s1;
					row_pixels_q  <= '0;
				end
				xsrb_pkg::MODE_READ: begin
					collision_q   <= 1'b0;
					sprite_done_q <= 1'b0;
					row_pixels_q  <= in_range_s1 ? xsrb_pkg::ROW_PIXELS_W'(cur_word) : '0;
				end
				default: begin
					collision_q   <= 1'b0;
					sprite_done_q <= 1'b0;
					row_pixels_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			hit_flag_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_commit && mode_s1 == xsrb_pkg::MODE_DRAW) begin
				hit_flag_q <= coll;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign collision   = collision_q;
	assign sprite_done = sprite_done_q;
	assign row_pixels  = row_pixels_q;

`ifndef NO_ASSERTIONS
	a_nondraw_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && mode_s1 != xsrb_pkg::MODE_DRAW |=> !collision && !sprite_done)
		else $error("non-draw word carries collision or done");

	a_nonread_pixels_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && mode_s1 != xsrb_pkg::MODE_READ |=> row_pixels == '0)
		else $error("non-read word carries pixels");

	a_hit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_commit && mode_s1 == xsrb_pkg::MODE_DRAW && row_zero_s1 && !hit_row
		|=> !hit_flag_q)
		else $error("collision flag did not restart at row zero");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(addr_s1))
		else $error("stalled word lost from stage 1");

	a_fwd_needs_commit: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && fwd_next |-> out_valid_q == 1'b0 || out_ready)
		else $error("forwarding without write-back");
`endif

endmodule
